// ----- hw/rtl/assert_macros.svh -----
// Assertion macros of the tuner search sequencer RTL.
// Bodies are empty when SYNTH is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define LTSS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ltss assertion failed");
`define LTSS_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("ltss assertion failed");
`else
`define LTSS_ASSERT(lbl, clk, rst_n, prop)
`define LTSS_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

// ----- hw/rtl/ltss_pkg.sv -----
// Types, constants and search tables of the tuner search sequencer.
// Used by the channel interfaces, the register block, the step logic and the top level.
`default_nettype none

package ltss_pkg;

  localparam int GridSideDef = 8;
  localparam int LadderBits  = 7;
  localparam int LadderHw    = (1 << LadderBits) - 1;
  localparam int PassCount   = 5;
  localparam int RefinePts   = 9;
  localparam int PctFull     = 100;
  localparam int SwrW        = 14;
  localparam int CodeW       = 7;
  localparam int CfgAddrW    = 5;

  localparam logic [15:0]      SwrNone     = 16'hFFFF;
  localparam logic [SwrW-1:0]  RepSwrReset = 14'd100;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_MEAS  = 2'd1,
    ACT_ABORT = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_TUNING = 3'd1,
    ST_OK     = 3'd2,
    ST_POOR   = 3'd3,
    ST_FAILED = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    KIND_GRID = 2'd0,
    KIND_L    = 2'd1,
    KIND_C    = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    REG_ENABLE   = 3'd0,
    REG_LADDER   = 3'd1,
    REG_SWR_GOOD = 3'd2,
    REG_SWR_OK   = 3'd3,
    REG_MAX_BAD  = 3'd4
  } reg_e;

  typedef struct packed {
    logic [1:0]      action;
    logic            start_permitted;
    logic            carrier_ok;
    logic [SwrW-1:0] swr_reading;
  } evt_t;

  typedef struct packed {
    logic [CodeW-1:0] relay_l;
    logic [CodeW-1:0] relay_c;
    logic             cap_radio_side;
    logic             bypass_on;
    logic [2:0]       tune_status;
    logic [SwrW-1:0]  result_swr;
    logic [6:0]       progress_pct;
    logic             start_accepted;
    logic             finished;
  } res_t;

  typedef struct packed {
    logic             tuner_enabled;
    logic [CodeW-1:0] ladder_max;
    logic [SwrW-1:0]  swr_good;
    logic [SwrW-1:0]  swr_ok;
    logic [3:0]       max_bad_reads;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    tuner_enabled: 1'b1,
    ladder_max:    7'd127,
    swr_good:      14'd110,
    swr_ok:        14'd200,
    max_bad_reads: 4'd5
  };

  // Geometric grid codes, one per grid row or column.
  function automatic logic [CodeW-1:0] grid_code(input logic [2:0] idx);
    logic [CodeW-1:0] code;
    case (idx)
      3'd0:    code = 7'd0;
      3'd1:    code = 7'd2;
      3'd2:    code = 7'd4;
      3'd3:    code = 7'd8;
      3'd4:    code = 7'd16;
      3'd5:    code = 7'd32;
      3'd6:    code = 7'd64;
      default: code = 7'd112;
    endcase
    return code;
  endfunction

  // Pass tables, indexed by pass number modulo the pass count.
  function automatic kind_e pass_kind(input logic [2:0] p);
    kind_e k;
    case (p)
      3'd0, 3'd5:       k = KIND_GRID;
      3'd1, 3'd3, 3'd6: k = KIND_L;
      default:          k = KIND_C;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] pass_span(input logic [2:0] p);
    logic [4:0] s;
    case (p)
      3'd0, 3'd5:       s = 5'd0;
      3'd1, 3'd2, 3'd6: s = 5'd16;
      default:          s = (p == 3'd7) ? 5'd16 : 5'd4;
    endcase
    return s;
  endfunction

  function automatic logic [2:0] pass_step(input logic [2:0] p);
    logic [2:0] s;
    case (p)
      3'd0, 3'd5:       s = 3'd0;
      3'd1, 3'd2, 3'd6: s = 3'd4;
      default:          s = (p == 3'd7) ? 3'd4 : 3'd1;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ltss_if.sv -----
// Request and result channel interfaces of the tuner search sequencer.
// Payload types come from ltss_pkg.
`default_nettype none

interface ltss_evt_if import ltss_pkg::*; ();
  logic valid;
  logic ready;
  evt_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ltss_res_if import ltss_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/lc_tuner_search_sequencer.sv -----
// L-network tuner search sequencer.
//
// Requests arrive on evt_i (valid/ready): start, measurement or abort. Each
// accepted request produces exactly one result on res_o carrying the relay
// codes to latch, the capacitor side, bypass, status, best SWR and progress.
// A request is taken into an input register, then evaluated combinationally
// against the search state, and the result lands in an output register.
// res_o.valid rises when the result is captured in the output register, and
// throughput is one request per cycle while res_o.ready is high, set by the
// combinational step logic between the two registers.
// While a result waits for res_o.ready, one more request can be held in the
// input register; further requests stall on evt_i.ready.
// Registers sit on an APB-style port (pready always high): enable, ladder
// limit, good and ok SWR thresholds, carrier-less read limit. Write them
// only while no request is in flight.
// After rst_ni the search is idle with relays in bypass, reported SWR 100,
// and the registers at their reset values.
`default_nettype none

module lc_tuner_search_sequencer import ltss_pkg::*; #(
  parameter int GridSide = GridSideDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  ltss_evt_if.sink            evt_i,
  ltss_res_if.source          res_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t cfg;
  evt_t evt_q;
  logic evt_vld_q;
  res_t step_res;
  res_t res_q;
  logic res_vld_q;
  logic go;

  assign go          = evt_vld_q && (!res_vld_q || res_o.ready);
  assign evt_i.ready = !evt_vld_q || go;
  assign res_o.valid = res_vld_q;
  assign res_o.data  = res_q;

  ltss_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ltss_step #(
    .GridSide (GridSide)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .evt_i  (evt_q),
    .cfg_i  (cfg),
    .res_o  (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (evt_i.ready) begin
        evt_vld_q <= evt_i.valid;
      end
      if (go) begin
        res_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_i.valid && evt_i.ready) begin
      evt_q <= evt_i.data;
    end
    if (go) begin
      res_q <= step_res;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ltss_cfg.sv -----
// APB-style configuration registers of the tuner search sequencer.
// Depends on ltss_pkg for the register map and reset values.
`default_nettype none

module ltss_cfg import ltss_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;
  reg_e sel;
  logic wr_en;

  assign sel    = reg_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (sel)
        REG_ENABLE:   cfg_d.tuner_enabled = pwdata[0];
        REG_LADDER:   cfg_d.ladder_max    = pwdata[CodeW-1:0];
        REG_SWR_GOOD: cfg_d.swr_good      = pwdata[SwrW-1:0];
        REG_SWR_OK:   cfg_d.swr_ok        = pwdata[SwrW-1:0];
        REG_MAX_BAD:  cfg_d.max_bad_reads = pwdata[3:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_ENABLE:   prdata = {31'd0, cfg_q.tuner_enabled};
      REG_LADDER:   prdata = {25'd0, cfg_q.ladder_max};
      REG_SWR_GOOD: prdata = {18'd0, cfg_q.swr_good};
      REG_SWR_OK:   prdata = {18'd0, cfg_q.swr_ok};
      REG_MAX_BAD:  prdata = {28'd0, cfg_q.max_bad_reads};
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ltss_step.sv -----
// Search state and combinational next-state logic of the tuner search sequencer.
// Depends on ltss_pkg and assert_macros.svh; the result is registered by the top level.
`default_nettype none
`include "assert_macros.svh"

module ltss_step import ltss_pkg::*; #(
  parameter int GridSide = GridSideDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic go_i,
  input  evt_t evt_i,
  input  cfg_t cfg_i,
  output res_t res_o
);

  localparam int GridPts   = GridSide * GridSide;
  localparam int LenMax    = (GridPts > RefinePts) ? GridPts : RefinePts;
  localparam int PtW       = $clog2(LenMax);
  localparam int PtN       = PtW + 1;
  localparam int RcW       = $clog2(GridSide);
  localparam int PassTotal = GridPts + 4 * RefinePts;
  localparam int StepTotal = 2 * PassTotal;
  localparam int RemW      = $clog2(StepTotal + PctFull);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TUNING,
    PH_DONE_OK,
    PH_FAILED
  } phase_e;

  phase_e           phase_q, phase_d;
  logic             half_q, half_d;
  logic [2:0]       pass_q, pass_d;
  logic [PtW-1:0]   point_q, point_d;
  logic [RcW-1:0]   row_q, row_d, col_q, col_d;
  logic [CodeW-1:0] work_l_q, work_l_d, work_c_q, work_c_d;
  logic [CodeW-1:0] center_q, center_d;
  logic [15:0]      pbest_swr_q, pbest_swr_d;
  logic [CodeW-1:0] pbest_l_q, pbest_l_d, pbest_c_q, pbest_c_d;
  logic [15:0]      best_swr_q, best_swr_d;
  logic [CodeW-1:0] best_l_q, best_l_d, best_c_q, best_c_d;
  logic             best_side_q, best_side_d, best_byp_q, best_byp_d;
  logic             probing_q, probing_d;
  logic [3:0]       bad_q, bad_d;
  logic             poor_q, poor_d;
  logic [SwrW-1:0]  rep_swr_q, rep_swr_d;
  logic [6:0]       pct_q, pct_d;
  logic [RemW-1:0]  rem_q, rem_d;

  logic             start_ok, fin, finish_ok, do_cursor;
  logic [3:0]       bad_inc;
  logic [PtN-1:0]   pt_n, pass_len;
  logic [2:0]       pass_n;
  logic [RemW-1:0]  rem_a;
  logic [1:0]       pct_inc;
  logic [15:0]      swr16;
  logic [7:0]       lim8;
  logic [CodeW-1:0] lim, gl, gc, v_clamp;
  kind_e            kind;
  logic [4:0]       span;
  logic [2:0]       stp;
  logic [9:0]       v;

  assign lim8 = ({1'b0, cfg_i.ladder_max} < 8'(LadderHw)) ? {1'b0, cfg_i.ladder_max}
                                                         : 8'(LadderHw);
  assign lim  = lim8[CodeW-1:0];

  always_comb begin
    phase_d     = phase_q;
    half_d      = half_q;
    pass_d      = pass_q;
    point_d     = point_q;
    row_d       = row_q;
    col_d       = col_q;
    work_l_d    = work_l_q;
    work_c_d    = work_c_q;
    center_d    = center_q;
    pbest_swr_d = pbest_swr_q;
    pbest_l_d   = pbest_l_q;
    pbest_c_d   = pbest_c_q;
    best_swr_d  = best_swr_q;
    best_l_d    = best_l_q;
    best_c_d    = best_c_q;
    best_side_d = best_side_q;
    best_byp_d  = best_byp_q;
    probing_d   = probing_q;
    bad_d       = bad_q;
    poor_d      = poor_q;
    rep_swr_d   = rep_swr_q;
    pct_d       = pct_q;
    rem_d       = rem_q;
    start_ok    = 1'b0;
    fin         = 1'b0;
    finish_ok   = 1'b0;
    do_cursor   = 1'b0;

    bad_inc  = bad_q + 4'd1;
    pt_n     = PtN'(point_q) + PtN'(1);
    pass_n   = pass_q + 3'd1;
    pass_len = (pass_q == 3'd0) ? PtN'(GridPts) : PtN'(RefinePts);
    swr16    = {2'b00, evt_i.swr_reading};

    // Progress is done * 100 / total, kept as quotient and remainder and
    // advanced by one point at a time.
    rem_a   = rem_q + RemW'(PctFull);
    pct_inc = 2'd0;
    if (rem_a >= RemW'(StepTotal)) begin
      rem_a   = rem_a - RemW'(StepTotal);
      pct_inc = pct_inc + 2'd1;
    end
    if (rem_a >= RemW'(StepTotal)) begin
      rem_a   = rem_a - RemW'(StepTotal);
      pct_inc = pct_inc + 2'd1;
    end

    case (action_e'(evt_i.action))
      ACT_START: begin
        if (cfg_i.tuner_enabled && phase_q != PH_TUNING && evt_i.start_permitted) begin
          half_d      = 1'b0;
          pass_d      = 3'd0;
          point_d     = '0;
          row_d       = '0;
          col_d       = '0;
          work_l_d    = '0;
          work_c_d    = '0;
          center_d    = '0;
          pbest_swr_d = '0;
          pbest_l_d   = '0;
          pbest_c_d   = '0;
          best_swr_d  = SwrNone;
          best_l_d    = '0;
          best_c_d    = '0;
          best_side_d = 1'b0;
          best_byp_d  = 1'b1;
          probing_d   = 1'b1;
          bad_d       = 4'd0;
          phase_d     = PH_TUNING;
          pct_d       = '0;
          rem_d       = '0;
          start_ok    = 1'b1;
        end
      end
      ACT_MEAS: begin
        if (phase_q == PH_TUNING) begin
          if (!cfg_i.tuner_enabled) begin
            phase_d = PH_FAILED;
          end else if (!evt_i.carrier_ok) begin
            bad_d = bad_inc;
            if (bad_inc >= cfg_i.max_bad_reads || bad_inc == 4'd0) begin
              phase_d = PH_FAILED;
            end
          end else begin
            bad_d = 4'd0;
            if (probing_q) begin
              probing_d   = 1'b0;
              best_swr_d  = swr16;
              best_l_d    = '0;
              best_c_d    = '0;
              best_side_d = 1'b0;
              best_byp_d  = 1'b1;
              if (evt_i.swr_reading <= cfg_i.swr_good) begin
                finish_ok = 1'b1;
              end else begin
                work_l_d    = '0;
                work_c_d    = '0;
                pass_d      = 3'd0;
                point_d     = '0;
                row_d       = '0;
                col_d       = '0;
                center_d    = '0;
                pbest_swr_d = SwrNone;
                pbest_l_d   = '0;
                pbest_c_d   = '0;
                do_cursor   = 1'b1;
              end
            end else begin
              if (swr16 < pbest_swr_q) begin
                pbest_swr_d = swr16;
                pbest_l_d   = work_l_q;
                pbest_c_d   = work_c_q;
              end
              if (swr16 < best_swr_q) begin
                best_swr_d  = swr16;
                best_l_d    = work_l_q;
                best_c_d    = work_c_q;
                best_side_d = half_q;
                best_byp_d  = 1'b0;
              end
              if (evt_i.swr_reading <= cfg_i.swr_good) begin
                finish_ok = 1'b1;
              end else begin
                pct_d     = pct_q + 7'(pct_inc);
                rem_d     = rem_a;
                do_cursor = 1'b1;
                if (pt_n >= pass_len) begin
                  // End of pass: continue from the best point of this pass.
                  work_l_d = pbest_l_d;
                  work_c_d = pbest_c_d;
                  pass_d   = pass_n;
                  point_d  = '0;
                  row_d    = '0;
                  col_d    = '0;
                  if (pass_n >= 3'(PassCount)) begin
                    if (half_q) begin
                      finish_ok = 1'b1;
                      do_cursor = 1'b0;
                    end else begin
                      half_d      = 1'b1;
                      work_l_d    = '0;
                      work_c_d    = '0;
                      pass_d      = 3'd0;
                      center_d    = '0;
                      pbest_swr_d = SwrNone;
                      pbest_l_d   = '0;
                      pbest_c_d   = '0;
                    end
                  end else begin
                    center_d    = (pass_kind(pass_n) == KIND_C) ? work_c_d : work_l_d;
                    pbest_swr_d = SwrNone;
                    pbest_l_d   = work_l_d;
                    pbest_c_d   = work_c_d;
                  end
                end else begin
                  point_d = pt_n[PtW-1:0];
                  if (pass_q == 3'd0) begin
                    if (col_q == RcW'(GridSide - 1)) begin
                      col_d = '0;
                      row_d = row_q + RcW'(1);
                    end else begin
                      col_d = col_q + RcW'(1);
                    end
                  end
                end
              end
            end
          end
          if (finish_ok) begin
            phase_d   = PH_DONE_OK;
            poor_d    = (best_swr_d > {2'b00, cfg_i.swr_ok});
            rep_swr_d = best_swr_d[SwrW-1:0];
          end
          fin = (phase_d != PH_TUNING);
        end
      end
      ACT_ABORT: begin
        if (phase_q == PH_TUNING) begin
          phase_d = PH_FAILED;
          fin     = 1'b1;
        end
      end
      default: ;
    endcase

    // Place the working point for the new cursor position.
    kind    = pass_kind(pass_d);
    span    = pass_span(pass_d);
    stp     = pass_step(pass_d);
    gl      = grid_code(3'(row_d));
    gc      = grid_code(3'(col_d));
    v       = 10'(center_d) - 10'(span) + 10'(point_d) * 10'(stp);
    v_clamp = v[9] ? '0 : ((v > 10'(lim)) ? lim : v[CodeW-1:0]);
    if (do_cursor) begin
      case (kind)
        KIND_GRID: begin
          work_l_d = (gl > lim) ? lim : gl;
          work_c_d = (gc > lim) ? lim : gc;
        end
        KIND_L:  work_l_d = v_clamp;
        KIND_C:  work_c_d = v_clamp;
        default: ;
      endcase
    end
  end

  always_comb begin
    res_o                = '0;
    res_o.start_accepted = start_ok;
    res_o.finished       = fin;
    res_o.result_swr     = rep_swr_d;
    res_o.bypass_on      = 1'b1;
    res_o.tune_status    = ST_IDLE;
    case (phase_d)
      PH_TUNING: begin
        res_o.tune_status  = ST_TUNING;
        res_o.progress_pct = pct_d;
        if (!probing_d) begin
          res_o.relay_l        = work_l_d;
          res_o.relay_c        = work_c_d;
          res_o.cap_radio_side = half_d;
          res_o.bypass_on      = 1'b0;
        end
      end
      PH_DONE_OK: begin
        res_o.tune_status    = poor_d ? ST_POOR : ST_OK;
        res_o.relay_l        = best_l_d;
        res_o.relay_c        = best_c_d;
        res_o.cap_radio_side = best_side_d;
        res_o.bypass_on      = best_byp_d;
        res_o.progress_pct   = 7'(PctFull);
      end
      PH_FAILED: begin
        res_o.tune_status  = ST_FAILED;
        res_o.progress_pct = 7'(PctFull);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      half_q      <= 1'b0;
      pass_q      <= 3'd0;
      point_q     <= '0;
      row_q       <= '0;
      col_q       <= '0;
      work_l_q    <= '0;
      work_c_q    <= '0;
      center_q    <= '0;
      pbest_swr_q <= SwrNone;
      pbest_l_q   <= '0;
      pbest_c_q   <= '0;
      best_swr_q  <= SwrNone;
      best_l_q    <= '0;
      best_c_q    <= '0;
      best_side_q <= 1'b0;
      best_byp_q  <= 1'b1;
      probing_q   <= 1'b0;
      bad_q       <= 4'd0;
      poor_q      <= 1'b0;
      rep_swr_q   <= RepSwrReset;
      pct_q       <= '0;
      rem_q       <= '0;
    end else if (go_i) begin
      phase_q     <= phase_d;
      half_q      <= half_d;
      pass_q      <= pass_d;
      point_q     <= point_d;
      row_q       <= row_d;
      col_q       <= col_d;
      work_l_q    <= work_l_d;
      work_c_q    <= work_c_d;
      center_q    <= center_d;
      pbest_swr_q <= pbest_swr_d;
      pbest_l_q   <= pbest_l_d;
      pbest_c_q   <= pbest_c_d;
      best_swr_q  <= best_swr_d;
      best_l_q    <= best_l_d;
      best_c_q    <= best_c_d;
      best_side_q <= best_side_d;
      best_byp_q  <= best_byp_d;
      probing_q   <= probing_d;
      bad_q       <= bad_d;
      poor_q      <= poor_d;
      rep_swr_q   <= rep_swr_d;
      pct_q       <= pct_d;
      rem_q       <= rem_d;
    end
  end

  `LTSS_ASSERT(a_fin_leaves_tuning, clk_i, rst_ni, go_i && res_o.finished |=> phase_q != PH_TUNING)
  `LTSS_ASSERT(a_start_probes, clk_i, rst_ni, go_i && res_o.start_accepted |=> probing_q && phase_q == PH_TUNING)
  `LTSS_ASSERT(a_pass_range, clk_i, rst_ni, phase_q == PH_TUNING && !probing_q |-> pass_q < 3'(PassCount))
  `LTSS_ASSERT(a_progress_range, clk_i, rst_ni, phase_q == PH_TUNING |-> pct_q < 7'(PctFull) && rem_q < RemW'(StepTotal))
  `LTSS_ASSERT_NORST(a_reset_idle, clk_i, !rst_ni |-> phase_q == PH_IDLE && !probing_q)

endmodule

`default_nettype wire
